// ----- rtl/aes_pkg.sv -----
// Package for the AES ECB/CBC block: payload structs, codes, state enum,
// S-box tables and round functions. No dependencies.
package aes_pkg;

	localparam int RkWords = 60;
	localparam int RkAw = 6;
	localparam int RkRounds = RkWords / 4;

	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_CHAIN_MODE = 3'd1;
	localparam logic [2:0] REG_KEY_WORD_0 = 3'd2;
	localparam logic [2:0] REG_KEY_WORD_3 = 3'd5;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;

	typedef struct packed {
		logic        op;
		logic        first_block;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [63:0] data;
	} aes_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXPAND, ST_LOAD, ST_FIRST, ST_ROUND, ST_DONE
	} aes_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             exp_init;
		logic             exp_step;
		logic             load;
		logic             rk_rd;
		logic [RkAw-1:0]  rk_addr;
		logic             add_key;
		logic             do_round;
		logic             last_round;
		logic             finish;
	} aes_cmd_t;

	typedef struct packed {
		logic [3:0] nk;
		logic [3:0] nr;
		logic       dec;
		logic       in_op;
	} aes_stat_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// State byte i (row i mod 4, column i div 4) sits at bits 127-8i.
	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) t[4*c+r] = b[4*((c+r)%4)+r];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (mix)
					o[127-8*(4*c+r) -: 8] = xt(t[4*c+r]) ^ xt(t[4*c+(r+1)%4])
						^ t[4*c+(r+1)%4] ^ t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4];
				else
					o[127-8*(4*c+r) -: 8] = t[4*c+r];
			end
		end
		return o;
	endfunction

	// Inverse shift and inverse S-box; the key is added by the caller.
	function automatic logic [127:0] dec_sub(input logic [127:0] s);
		logic [127:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[s[127-8*(4*c+r) -: 8]];
		return o;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = s[127-8*(4*c+k) -: 8];
				x2[k] = xt(a[k]);
				x4[k] = xt(x2[k]);
				x8[k] = xt(x4[k]);
			end
			for (int r = 0; r < 4; r++)
				o[127-8*(4*c+r) -: 8] =
					(x8[r] ^ x4[r] ^ x2[r])
					^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
					^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
					^ (x8[(r+3)%4] ^ a[(r+3)%4]);
		end
		return o;
	endfunction

endpackage

// ----- rtl/aes_ctrl.sv -----
// Controller for the AES block: sequences key expansion, rounds and output.
// Depends on aes_pkg.
module aes_ctrl import aes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_busy,
	input  logic      cfg_key_write,
	input  aes_stat_t stat,
	output aes_cmd_t  cmd
);

	aes_state_t state_q, state_d;
	logic       keys_ready_q;
	logic [RkAw-1:0] idx_q, idx_d;
	logic [3:0] rnd_q, rnd_d;
	logic [RkAw-1:0] total;
	logic [RkAw-1:0] rd_addr;

	// Four words per round key, nk + 7 round keys.
	assign total = RkAw'({stat.nk, 2'b00}) + RkAw'(5'd28);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		rnd_d = rnd_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					idx_d = '0;
					state_d = keys_ready_q ? ST_LOAD : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				idx_d = idx_q + 1'b1;
				if (idx_q == total - 1'b1) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				rnd_d = 4'd1;
				state_d = ST_FIRST;
			end
			ST_FIRST: state_d = ST_ROUND;
			ST_ROUND: begin
				rnd_d = rnd_q + 1'b1;
				if (rnd_q == stat.nr) state_d = ST_DONE;
			end
			ST_DONE: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Round key read this cycle, used by the step in the next one.
	// The block is loaded this cycle in the load state, so its op comes from the input.
	always_comb begin
		logic [3:0] r;
		r = '0;
		case (state_q)
			ST_LOAD:  r = stat.in_op ? stat.nr : 4'd0;
			ST_FIRST: r = stat.dec ? stat.nr - 4'd1 : 4'd1;
			ST_ROUND: r = stat.dec ? stat.nr - rnd_q - 4'd1 : rnd_q + 4'd1;
			default:  r = '0;
		endcase
		rd_addr = {r, 2'b00};
	end

	always_comb begin
		cmd = '0;
		cmd.rk_addr = rd_addr;
		case (state_q)
			ST_IDLE: cmd.exp_init = in_valid && !keys_ready_q;
			ST_EXPAND: cmd.exp_step = 1'b1;
			ST_LOAD: begin
				cmd.load = 1'b1;
				cmd.rk_rd = 1'b1;
			end
			ST_FIRST: begin
				cmd.add_key = 1'b1;
				cmd.rk_rd = 1'b1;
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
				cmd.last_round = rnd_q == stat.nr;
				cmd.rk_rd = rnd_q != stat.nr;
			end
			ST_DONE: cmd.finish = !out_busy;
			default: cmd = '0;
		endcase
	end

	assign in_ready = state_q == ST_DONE && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keys_ready_q <= 1'b0;
			idx_q <= '0;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			rnd_q <= rnd_d;
			if (cfg_key_write) keys_ready_q <= 1'b0;
			else if (state_q == ST_EXPAND && state_d == ST_LOAD) keys_ready_q <= 1'b1;
		end
	end

endmodule

// ----- rtl/aes_dp.sv -----
// Datapath for the AES block: config registers, round-key store, key
// expansion, state register, chain register and output register. Uses aes_pkg.
module aes_dp import aes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  aes_cfg_t  cfg,
	input  aes_in_t   din,
	input  aes_cmd_t  cmd,
	output aes_stat_t stat,
	output logic      out_busy,
	input  logic      out_ready,
	output logic      out_valid,
	output aes_out_t  dout
);

	logic [1:0]   key_size_q;
	logic         chain_mode_q;
	logic [63:0]  key_q [4];
	// One entry per round key; word 4r+j of the schedule sits at bits 127-32j.
	logic [127:0] rk_mem [RkRounds];
	logic [31:0]  win_q [8];
	logic [RkAw-1:0] widx_q;
	logic [3:0]   wmod_q;
	logic [7:0]   rcon_q;
	logic [127:0] rk_s1;
	logic [127:0] st_q;
	logic [127:0] chain_q;
	logic [127:0] blk_q;
	logic         dec_q, first_q;
	logic         out_valid_q;
	aes_out_t     dout_q;
	logic [31:0]  new_w, t_w, prev_w;
	logic [3:0]   nk;
	logic [127:0] ch;

	assign nk = key_size_q == KS_128 ? 4'd4 : (key_size_q == KS_192 ? 4'd6 : 4'd8);
	assign stat.nk = nk;
	assign stat.nr = nk + 4'd6;
	assign stat.dec = dec_q;
	assign stat.in_op = din.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			chain_mode_q <= 1'b0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg.index == REG_KEY_SIZE) key_size_q <= cfg.data[1:0];
			else if (cfg.index == REG_CHAIN_MODE) chain_mode_q <= cfg.data[0];
			else if (cfg.index >= REG_KEY_WORD_0 && cfg.index <= REG_KEY_WORD_3)
				key_q[2'(cfg.index - REG_KEY_WORD_0)] <= cfg.data;
		end
	end

	// Key schedule: an eight-word window holds the last nk words.
	assign prev_w = win_q[3'(nk - 4'd1)];
	always_comb begin
		t_w = prev_w;
		if (wmod_q == 4'd0)
			t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'h0};
		else if (nk == 4'd8 && wmod_q == 4'd4)
			t_w = sub_word(prev_w);
		new_w = win_q[0] ^ t_w;
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_init) begin
			for (int i = 0; i < 4; i++) begin
				win_q[2*i] <= key_q[i][63:32];
				win_q[2*i+1] <= key_q[i][31:0];
			end
			widx_q <= '0;
			wmod_q <= '0;
			rcon_q <= 8'h01;
		end else if (cmd.exp_step) begin
			// The first nk words are the key itself.
			if (widx_q < RkAw'(nk)) begin
				rk_mem[widx_q[RkAw-1:2]][32*(3-int'(widx_q[1:0])) +: 32] <=
					win_q[3'(widx_q)];
			end else begin
				rk_mem[widx_q[RkAw-1:2]][32*(3-int'(widx_q[1:0])) +: 32] <= new_w;
				for (int i = 0; i < 7; i++)
					if (i < 32'(nk) - 1) win_q[i] <= win_q[i+1];
				win_q[3'(nk - 4'd1)] <= new_w;
				if (wmod_q == 4'd0) rcon_q <= xt(rcon_q);
				wmod_q <= wmod_q == nk - 4'd1 ? 4'd0 : wmod_q + 4'd1;
			end
			widx_q <= widx_q + 1'b1;
		end
		if (cmd.rk_rd)
			rk_s1 <= rk_mem[cmd.rk_addr[RkAw-1:2]];
	end

	assign ch = (chain_mode_q && !first_q) ? chain_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dec_q <= din.op;
			first_q <= din.first_block;
			blk_q <= {din.block_high, din.block_low};
			st_q <= {din.block_high, din.block_low};
		end else if (cmd.add_key) begin
			st_q <= (dec_q ? st_q : st_q ^ ch) ^ rk_s1;
		end else if (cmd.do_round) begin
			if (!dec_q)
				st_q <= enc_round(st_q, !cmd.last_round) ^ rk_s1;
			else if (cmd.last_round)
				st_q <= dec_sub(st_q) ^ rk_s1 ^ ch;
			else
				st_q <= inv_mix(dec_sub(st_q) ^ rk_s1);
		end
		if (cmd.finish) dout_q <= st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (chain_mode_q) chain_q <= dec_q ? blk_q : st_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign dout = dout_q;

endmodule

// ----- rtl/aes_block_cipher_ecb_cbc.sv -----
// Top level of the AES-128/192/256 ECB/CBC block cipher.
// Depends on aes_pkg, aes_ctrl and aes_dp.
//
//   channel  handshake             payload
//   in       in_valid/in_ready     aes_in_t  (op, first_block, block)
//   out      out_valid/out_ready   aes_out_t (result)
//   cfg      cfg_valid/cfg_ready   aes_cfg_t (index, data)
//
// A block runs through the load, first-key, round and done states, one round per cycle.
// After reset or a key write, the next block first runs the key expansion,
// one round-key word per cycle.
// The input item is taken when its result is loaded into the output
// register; a stalled output holds the controller until space frees.
module aes_block_cipher_ecb_cbc import aes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  aes_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output aes_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  aes_cfg_t cfg_data
);

	aes_cmd_t  cmd;
	aes_stat_t stat;
	logic      out_busy;
	logic      cfg_we;
	logic      key_write;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid;
	assign key_write = cfg_we && cfg_data.index != REG_CHAIN_MODE
		&& cfg_data.index <= REG_KEY_WORD_3;

	aes_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_busy,
		.cfg_key_write(key_write), .stat, .cmd
	);

	aes_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg(cfg_data), .din(in_data), .cmd, .stat,
		.out_busy, .out_ready, .out_valid, .dout(out_data)
	);

endmodule

// ----- rtl/aes_chk.sv -----
// Port checker for the AES block, bound to the top level.
// Depends on aes_pkg.
module aes_chk import aes_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input aes_out_t out_data
);

	// An item is accepted only as its result appears.
	a_acc_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid) else $error("no result after item");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_ready_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> in_valid) else $error("ready without item");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("two items back to back");

endmodule

bind aes_block_cipher_ecb_cbc aes_chk u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
